/* rtl/spq_pkg.sv */
package spq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int PRIO_BITS_DEFAULT = 8;
    localparam int DATA_BITS_DEFAULT = 32;

    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        t_status           status;
        logic [FILL_W-1:0] fill;
    } t_result;

endpackage

/* rtl/spq_cell.sv */
module spq_cell #(
    parameter int DW = 32,
    parameter int PW = 8
) (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic [DW-1:0]      i_new_data,
    input  logic [PW-1:0]      i_new_prio,
    input  logic               i_left_le,
    input  logic [DW-1:0]      i_left_data,
    input  logic [PW-1:0]      i_left_prio,
    input  logic [DW-1:0]      i_right_data,
    input  logic [PW-1:0]      i_right_prio,
    output logic               o_le,
    output logic [DW-1:0]      o_data,
    output logic [PW-1:0]      o_prio
);
    import spq_pkg::*;

    logic [DW-1:0] r_data;
    logic [PW-1:0] r_prio;

    // A held entry stays put when it sorts at or ahead of the new one.
    assign o_le   = i_valid && (r_prio <= i_new_prio);
    assign o_data = r_data;
    assign o_prio = r_prio;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !o_le) begin
            if (i_left_le) begin
                r_data <= i_new_data;
                r_prio <= i_new_prio;
            end else begin
                r_data <= i_left_data;
                r_prio <= i_left_prio;
            end
        end else if (i_ctl.del) begin
            r_data <= i_right_data;
            r_prio <= i_right_prio;
        end
    end

endmodule

/* rtl/stable_priority_queue.sv */
// Channel  Valid        Stall        Word
// input    i_in_valid   o_in_stall   i_action, i_data_in, i_prio_in
// output   o_out_valid  i_out_stall  o_data_out, o_prio_out, o_status, o_fill_level
//
// Every cell compares its priority with the new word in the same cycle, so one
// word is taken per cycle while o_in_stall is low; its result is registered at the
// accepting edge and offered in the next cycle if the output register is free, else held in the skid slot.
// A two-deep output buffer lets input continue while a result waits; input
// stalls only when both output slots are full.
// Reset empties the queue at once; the cell contents are left as they are.
module stable_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEFAULT,
    parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEFAULT,
    parameter int DATA_BITS = spq_pkg::DATA_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_action,
    input  logic signed [spq_pkg::DATA_W-1:0]     i_data_in,
    input  logic [spq_pkg::PRIO_W-1:0]            i_prio_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [spq_pkg::DATA_W-1:0]     o_data_out,
    output logic [spq_pkg::PRIO_W-1:0]            o_prio_out,
    output logic [spq_pkg::STATUS_W-1:0]          o_status,
    output logic [spq_pkg::FILL_W-1:0]            o_fill_level
);
    import spq_pkg::*;

    localparam int DW = (DATA_BITS < DATA_W) ? DATA_BITS : DATA_W;
    localparam int PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;
    t_cell_ctl     w_ctl;
    t_result       w_res;
    t_result       r_out;
    t_result       r_skid;
    logic          r_out_valid;
    logic          r_skid_valid;
    logic [DW-1:0] w_new_data;
    logic [PW-1:0] w_new_prio;

    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_le;
    logic [DEPTH-1:0][DW-1:0] w_data;
    logic [DEPTH-1:0][PW-1:0] w_prio;

    assign w_new_data = i_data_in[DW-1:0];
    assign w_new_prio = i_prio_in[PW-1:0];
    assign o_in_stall = r_skid_valid;
    assign w_push     = i_in_valid && !r_skid_valid;
    assign w_pop      = r_out_valid && !i_out_stall;

    always_comb begin
        w_ctl.ins  = w_push && (i_action == ACT_ENQ) && (r_count != CW'(DEPTH));
        w_ctl.del  = w_push && (i_action == ACT_DEQ) && (r_count != '0);
        n_count    = r_count;
        w_res.data = '0;
        w_res.prio = '0;
        if (i_action == ACT_ENQ) begin
            w_res.status = (r_count != CW'(DEPTH)) ? ST_INSERTED : ST_FULL;
        end else begin
            w_res.status = (r_count != '0) ? ST_DEQUEUED : ST_EMPTY;
        end
        if (w_ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.del) begin
            n_count    = r_count - 1'b1;
            w_res.data = DATA_W'(w_data[0]);
            w_res.prio = PRIO_W'(w_prio[0]);
        end
        w_res.fill = FILL_W'(n_count);
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic          w_left_le;
        logic [DW-1:0] w_left_data;
        logic [PW-1:0] w_left_prio;
        logic [DW-1:0] w_right_data;
        logic [PW-1:0] w_right_prio;

        assign w_valid[i] = r_count > CW'(i);

        if (i == 0) begin : g_head
            assign w_left_le   = 1'b1;
            assign w_left_data = '0;
            assign w_left_prio = '0;
        end else begin : g_body
            assign w_left_le   = w_le[i-1];
            assign w_left_data = w_data[i-1];
            assign w_left_prio = w_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_right_data = '0;
            assign w_right_prio = '0;
        end else begin : g_next
            assign w_right_data = w_data[i+1];
            assign w_right_prio = w_prio[i+1];
        end

        spq_cell #(
            .DW (DW),
            .PW (PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (w_valid[i]),
            .i_new_data   (w_new_data),
            .i_new_prio   (w_new_prio),
            .i_left_le    (w_left_le),
            .i_left_data  (w_left_data),
            .i_left_prio  (w_left_prio),
            .i_right_data (w_right_data),
            .i_right_prio (w_right_prio),
            .o_le         (w_le[i]),
            .o_data       (w_data[i]),
            .o_prio       (w_prio[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end
        if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out.data;
    assign o_prio_out   = r_out.prio;
    assign o_status     = r_out.status;
    assign o_fill_level = r_out.fill;

endmodule

/* tb/spq_order_checker.sv */
module spq_order_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_stall,
    input  logic                              i_action,
    input  logic signed [spq_pkg::DATA_W-1:0] i_data_in,
    input  logic [spq_pkg::PRIO_W-1:0]        i_prio_in,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [spq_pkg::DATA_W-1:0] o_data_out,
    input  logic [spq_pkg::PRIO_W-1:0]        o_prio_out,
    input  logic [spq_pkg::STATUS_W-1:0]      o_status,
    input  logic [spq_pkg::FILL_W-1:0]        o_fill_level,
    output int                                o_fail_count,
    output int                                o_pending
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] slot_data [DEPTH];
    logic [PRIO_W-1:0]        slot_prio [DEPTH];
    int                       held = 0;
    t_result                  pending_results [$];
    int                       mismatches = 0;
    int                       results_seen = 0;

    // Models the sorted store: a new entry goes behind every entry of lower
    // or equal priority, and a removal always takes slot zero.
    function automatic t_result serve_word(input logic act,
                                           input logic signed [DATA_W-1:0] d,
                                           input logic [PRIO_W-1:0] p);
        t_result r;
        int      pos;
        int      i;
        r = '{data: '0, prio: '0, status: ST_INSERTED, fill: '0};
        if (act == ACT_ENQ) begin
            if (held >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && slot_prio[pos] <= p) pos++;
                for (i = held; i > pos; i--) begin
                    slot_data[i] = slot_data[i-1];
                    slot_prio[i] = slot_prio[i-1];
                end
                slot_data[pos] = d;
                slot_prio[pos] = p;
                held++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (held == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.data = slot_data[0];
                r.prio = slot_prio[0];
                for (i = 1; i < held; i++) begin
                    slot_data[i-1] = slot_data[i];
                    slot_prio[i-1] = slot_prio[i];
                end
                held--;
                r.status = ST_DEQUEUED;
            end
        end
        r.fill = held[FILL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch on result %0d: %s got %0h want %0h", results_seen, what, got,
                 want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing expected, status",
                                    DATA_W'(o_status), '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_data_out !== want.data)
                        report_mismatch("data", o_data_out, want.data);
                    if (o_prio_out !== want.prio)
                        report_mismatch("priority", DATA_W'(o_prio_out),
                                        DATA_W'(want.prio));
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(o_status),
                                        DATA_W'(want.status));
                    if (o_fill_level !== want.fill)
                        report_mismatch("fill level", DATA_W'(o_fill_level),
                                        DATA_W'(want.fill));
                end
                results_seen++;
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(serve_word(i_action, i_data_in, i_prio_in));
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

/* tb/stable_priority_queue_test.sv */
module stable_priority_queue_test;
    import spq_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_action = ACT_ENQ;
    logic signed [DATA_W-1:0] i_data_in = '0;
    logic [PRIO_W-1:0]        i_prio_in = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_data_out;
    logic [PRIO_W-1:0]        o_prio_out;
    logic [STATUS_W-1:0]      o_status;
    logic [FILL_W-1:0]        o_fill_level;
    int                       o_fail_count;
    int                       o_pending;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    stable_priority_queue dut (.*);

    spq_order_checker checker_i (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_800_000;
        $display("[stable_priority_queue] ERROR");
        $finish;
    end

    // A hold request keeps the output stalled for a long stretch so that the
    // queue's output buffer fills and the input side has to stall.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = 80;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    task automatic send_word(input logic act, input logic signed [DATA_W-1:0] d,
                             input logic [PRIO_W-1:0] p);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_data_in  <= d;
        i_prio_in  <= p;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_queue();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (o_pending != 0);
    endtask

    task automatic random_words(input int count);
        int   enq_pct;
        int   k;
        logic act;
        logic [PRIO_W-1:0] p;
        enq_pct = 50;
        for (k = 0; k < count; k++) begin
            if (k % 40 == 0) enq_pct = $urandom_range(20, 80);
            act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
            p = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                             : $urandom_range(0, 255));
            send_word(act, $urandom, p);
        end
    endtask

    initial begin
        int k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(ACT_DEQ, 32'sh1234_5678, 8'd9);
        send_word(ACT_ENQ, 32'sh7FFF_FFFF, 8'd255);
        send_word(ACT_ENQ, 32'sh8000_0000, 8'd0);
        send_word(ACT_ENQ, -32'sd1, 8'd255);
        send_word(ACT_ENQ, 32'sd0, 8'd128);
        for (k = 0; k < 12; k++)
            send_word(ACT_ENQ, 100 + k, PRIO_W'(7 - (k % 3)));
        send_word(ACT_ENQ, 32'sh5555_5555, 8'd1);
        for (k = 0; k < 6; k++)
            send_word(ACT_DEQ, '0, '0);
        drain_queue();

        hold_requests++;
        random_words(470);
        drain_queue();

        tx_idle_pct = 83;
        random_words(470);
        drain_queue();

        tx_idle_pct = 0;
        rx_stall_pct = 83;
        random_words(470);
        drain_queue();

        tx_idle_pct = 18;
        rx_stall_pct = 18;
        random_words(470);

        drain_queue();
        repeat (10) @(posedge i_clk);
        if (o_fail_count == 0) begin
            $display("[stable_priority_queue] OK");
        end else begin
            $display("[stable_priority_queue] ERROR");
        end
        $finish;
    end

endmodule
